// ----- design/wbrc_pkg.sv -----
// Package for the write-back record cache: op and result kind codes,
// controller state encoding and the controller/datapath command and status structs.
// No dependencies.
package wbrc_pkg;

	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_FLUSH_ONE = 3'd2;
	localparam logic [2:0] OP_FLUSH_ALL = 3'd3;
	localparam logic [2:0] OP_FILL      = 3'd4;

	localparam logic [1:0] KIND_READ_DATA  = 2'd0;
	localparam logic [1:0] KIND_WRITE_BACK = 2'd1;
	localparam logic [1:0] KIND_FETCH      = 2'd2;
	localparam logic [1:0] KIND_DONE       = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_EMIT1  = 6'b000100,
		ST_EMIT2  = 6'b001000,
		ST_SWEEP  = 6'b010000,
		ST_SWEMIT = 6'b100000
	} ctl_state_t;

	// Datapath actions requested by the controller.
	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_CAPTURE   = 4'd1,
		ACT_DECIDE    = 4'd2,
		ACT_LOAD_RES1 = 4'd3,
		ACT_LOAD_RES2 = 4'd4,
		ACT_SWEEP     = 4'd5,
		ACT_LOAD_SW   = 4'd6,
		ACT_LOAD_SWD  = 4'd7
	} dp_act_t;

	typedef struct packed {
		dp_act_t act;
	} dp_cmd_t;

	typedef struct packed {
		logic       drop;       // request produces no result
		logic       two_res;    // request produces two results
		logic       sw_found;   // sweep found a dirty entry
		logic       sw_done;    // sweep pointer passed the last entry
		logic       sw_any;     // sweep emitted at least one write-back
	} dp_stat_t;

endpackage

// ----- design/wbrc_datapath.sv -----
// Datapath of the write-back record cache: entry arrays, tag compare,
// victim choice, flush sweep pointer and the output register.
// Depends on wbrc_pkg.
module wbrc_datapath #(
	parameter int ENTRIES    = 16,
	parameter int INDEX_BITS = 16,
	parameter int DATA_BITS  = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wbrc_pkg::dp_cmd_t      cmd,
	output wbrc_pkg::dp_stat_t     stat,
	input  logic [2:0]             op,
	input  logic [INDEX_BITS-1:0]  record_index,
	input  logic [DATA_BITS-1:0]   record_data,
	input  logic [15:0]            victim_hint,
	output logic [1:0]             kind,
	output logic [INDEX_BITS-1:0]  result_index,
	output logic [DATA_BITS-1:0]   result_data,
	output logic                   last
);

	localparam int SW = $clog2(ENTRIES);

	logic [ENTRIES-1:0]    valid_q;
	logic [ENTRIES-1:0]    dirty_q;
	logic [INDEX_BITS-1:0] tag_q  [ENTRIES];
	logic [DATA_BITS-1:0]  word_q [ENTRIES];

	logic                  pend_q;
	logic [SW-1:0]         pend_slot_q;
	logic [INDEX_BITS-1:0] pend_idx_q;

	// Captured request
	logic [2:0]            op_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [DATA_BITS-1:0]  data_q;
	logic [15:0]           hint_q;

	// Decision results
	logic                  drop_q;
	logic                  two_q;
	logic [1:0]            k1_q, k2_q;
	logic [INDEX_BITS-1:0] i1_q, i2_q;
	logic [DATA_BITS-1:0]  d1_q, d2_q;

	// Sweep state
	logic [SW:0]           ptr_q;
	logic                  any_q;
	logic [INDEX_BITS-1:0] sw_idx_q;
	logic [DATA_BITS-1:0]  sw_data_q;
	logic                  sw_found_q;

	// Tag compare and victim search
	logic               hit;
	logic [SW-1:0]      hit_slot;
	logic               inv_found, cln_found;
	logic [SW-1:0]      inv_slot, cln_slot;
	always_comb begin
		hit = 1'b0; hit_slot = '0;
		inv_found = 1'b0; inv_slot = '0;
		cln_found = 1'b0; cln_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == idx_q) begin
				hit = 1'b1; hit_slot = SW'(i);
			end
			if (!valid_q[i]) begin
				inv_found = 1'b1; inv_slot = SW'(i);
			end
			if (!dirty_q[i]) begin
				cln_found = 1'b1; cln_slot = SW'(i);
			end
		end
	end

	logic [15:0]   fb_val;
	logic [SW-1:0] victim;
	logic [SW-1:0] tgt;
	always_comb begin
		fb_val = (op_q == wbrc_pkg::OP_READ) ? 16'(idx_q) : hint_q;
		if (inv_found)      victim = inv_slot;
		else if (cln_found) victim = cln_slot;
		else                victim = SW'(fb_val % ENTRIES);
		tgt = (op_q == wbrc_pkg::OP_WRITE && hit) ? hit_slot : victim;
	end

	logic [SW-1:0] ptr_idx;
	assign ptr_idx = ptr_q[SW-1:0];

	// Flag a dirty entry still ahead of the sweep pointer
	logic more_dirty;
	always_comb begin
		more_dirty = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (valid_q[i] && dirty_q[i] && (SW+1)'(i) >= ptr_q)
				more_dirty = 1'b1;
	end

	assign stat.drop     = drop_q;
	assign stat.two_res  = two_q;
	assign stat.sw_found = sw_found_q;
	assign stat.sw_done  = (ptr_q == (SW+1)'(ENTRIES));
	assign stat.sw_any   = any_q;

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.act)
			wbrc_pkg::ACT_CAPTURE: begin
				op_q <= op; idx_q <= record_index;
				data_q <= record_data; hint_q <= victim_hint;
			end
			wbrc_pkg::ACT_DECIDE: begin
				k1_q <= wbrc_pkg::KIND_DONE; i1_q <= idx_q; d1_q <= '0;
				k2_q <= wbrc_pkg::KIND_DONE; i2_q <= idx_q; d2_q <= '0;
				case (op_q)
					wbrc_pkg::OP_FILL: begin
						k1_q <= wbrc_pkg::KIND_READ_DATA; i1_q <= pend_idx_q;
						d1_q <= data_q;
						if (pend_q) begin
							tag_q[pend_slot_q] <= pend_idx_q;
							word_q[pend_slot_q] <= data_q;
						end
					end
					wbrc_pkg::OP_READ: begin
						if (hit) begin
							k1_q <= wbrc_pkg::KIND_READ_DATA;
							d1_q <= word_q[hit_slot];
						end else begin
							k1_q <= wbrc_pkg::KIND_WRITE_BACK;
							i1_q <= tag_q[victim]; d1_q <= word_q[victim];
							k2_q <= wbrc_pkg::KIND_FETCH;
							k1_q <= (valid_q[victim] && dirty_q[victim])
								? wbrc_pkg::KIND_WRITE_BACK : wbrc_pkg::KIND_FETCH;
							if (!(valid_q[victim] && dirty_q[victim])) begin
								i1_q <= idx_q; d1_q <= '0;
							end
						end
					end
					wbrc_pkg::OP_WRITE: begin
						if (!hit && valid_q[victim] && dirty_q[victim]) begin
							k1_q <= wbrc_pkg::KIND_WRITE_BACK;
							i1_q <= tag_q[victim]; d1_q <= word_q[victim];
						end
						if (!pend_q) begin
							tag_q[tgt] <= idx_q;
							word_q[tgt] <= data_q;
						end
					end
					wbrc_pkg::OP_FLUSH_ONE: begin
						if (hit && dirty_q[hit_slot]) begin
							k1_q <= wbrc_pkg::KIND_WRITE_BACK;
							d1_q <= word_q[hit_slot];
						end
					end
					default: ;
				endcase
			end
			wbrc_pkg::ACT_SWEEP: begin
				sw_idx_q <= tag_q[ptr_idx];
				sw_data_q <= word_q[ptr_idx];
			end
			wbrc_pkg::ACT_LOAD_RES1: begin
				kind <= k1_q; result_index <= i1_q; result_data <= d1_q;
				last <= !two_q;
			end
			wbrc_pkg::ACT_LOAD_RES2: begin
				kind <= k2_q; result_index <= i2_q; result_data <= d2_q;
				last <= 1'b1;
			end
			wbrc_pkg::ACT_LOAD_SW: begin
				kind <= wbrc_pkg::KIND_WRITE_BACK; result_index <= sw_idx_q;
				result_data <= sw_data_q;
				last <= !more_dirty;
			end
			wbrc_pkg::ACT_LOAD_SWD: begin
				kind <= wbrc_pkg::KIND_DONE; result_index <= '0;
				result_data <= '0; last <= 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers: valid, dirty, pending fetch, decision flags and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; dirty_q <= '0;
			pend_q <= 1'b0; pend_slot_q <= '0; pend_idx_q <= '0;
			drop_q <= 1'b0; two_q <= 1'b0;
			ptr_q <= '0; any_q <= 1'b0; sw_found_q <= 1'b0;
		end else begin
			unique case (cmd.act)
				wbrc_pkg::ACT_CAPTURE: begin
					ptr_q <= '0; any_q <= 1'b0; sw_found_q <= 1'b0;
				end
				wbrc_pkg::ACT_DECIDE: begin
					drop_q <= 1'b0; two_q <= 1'b0;
					if (op_q == wbrc_pkg::OP_FILL) begin
						if (!pend_q) drop_q <= 1'b1;
						else begin
							valid_q[pend_slot_q] <= 1'b1;
							dirty_q[pend_slot_q] <= 1'b0;
							pend_q <= 1'b0;
						end
					end else if (op_q > wbrc_pkg::OP_FILL || pend_q) begin
						drop_q <= 1'b1;
					end else begin
						case (op_q)
							wbrc_pkg::OP_READ: begin
								if (!hit) begin
									two_q <= valid_q[victim] && dirty_q[victim];
									valid_q[victim] <= 1'b0;
									dirty_q[victim] <= 1'b0;
									pend_q <= 1'b1; pend_slot_q <= victim;
									pend_idx_q <= idx_q;
								end
							end
							wbrc_pkg::OP_WRITE: begin
								two_q <= !hit && valid_q[victim] && dirty_q[victim];
								valid_q[tgt] <= 1'b1; dirty_q[tgt] <= 1'b1;
							end
							wbrc_pkg::OP_FLUSH_ONE: begin
								if (hit) dirty_q[hit_slot] <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				wbrc_pkg::ACT_SWEEP: begin
					sw_found_q <= valid_q[ptr_idx] && dirty_q[ptr_idx];
					if (valid_q[ptr_idx] && dirty_q[ptr_idx]) begin
						dirty_q[ptr_idx] <= 1'b0; any_q <= 1'b1;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- design/wbrc_ctrl.sv -----
// Controller of the write-back record cache: sequences capture, decision,
// result emission and the flush-all sweep. Depends on wbrc_pkg.
module wbrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          op,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output wbrc_pkg::dp_cmd_t   cmd,
	input  wbrc_pkg::dp_stat_t  stat
);

	wbrc_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic flush_all_q;

	assign in_ready  = (state_q == wbrc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath command
	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd.act = wbrc_pkg::ACT_NONE;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			wbrc_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.act = wbrc_pkg::ACT_CAPTURE;
					state_d = wbrc_pkg::ST_DECIDE;
				end
			end
			wbrc_pkg::ST_DECIDE: begin
				cmd.act = wbrc_pkg::ACT_DECIDE;
				state_d = wbrc_pkg::ST_EMIT1;
			end
			wbrc_pkg::ST_EMIT1: begin
				if (stat.drop) begin
					state_d = wbrc_pkg::ST_IDLE;
				end else if (flush_all_q) begin
					state_d = wbrc_pkg::ST_SWEEP;
				end else if (!out_valid_q || out_ready) begin
					cmd.act = wbrc_pkg::ACT_LOAD_RES1;
					out_valid_d = 1'b1;
					state_d = stat.two_res ? wbrc_pkg::ST_EMIT2 : wbrc_pkg::ST_IDLE;
				end
			end
			wbrc_pkg::ST_EMIT2: begin
				if (!out_valid_q || out_ready) begin
					cmd.act = wbrc_pkg::ACT_LOAD_RES2;
					out_valid_d = 1'b1;
					state_d = wbrc_pkg::ST_IDLE;
				end
			end
			wbrc_pkg::ST_SWEEP: begin
				// Visit the next entry, or finish the sweep
				if (stat.sw_done) begin
					if (!stat.sw_any) begin
						if (!out_valid_q || out_ready) begin
							cmd.act = wbrc_pkg::ACT_LOAD_SWD;
							out_valid_d = 1'b1;
							state_d = wbrc_pkg::ST_IDLE;
						end
					end else begin
						state_d = wbrc_pkg::ST_IDLE;
					end
				end else begin
					cmd.act = wbrc_pkg::ACT_SWEEP;
					state_d = wbrc_pkg::ST_SWEMIT;
				end
			end
			wbrc_pkg::ST_SWEMIT: begin
				// Emit a found dirty entry once the output register is free
				if (!stat.sw_found) begin
					state_d = wbrc_pkg::ST_SWEEP;
				end else if (!out_valid_q || out_ready) begin
					cmd.act = wbrc_pkg::ACT_LOAD_SW;
					out_valid_d = 1'b1;
					state_d = wbrc_pkg::ST_SWEEP;
				end
			end
			default: state_d = wbrc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbrc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			flush_all_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
			if (cmd.act == wbrc_pkg::ACT_CAPTURE)
				flush_all_q <= (op == wbrc_pkg::OP_FLUSH_ALL);
		end
	end

endmodule

// ----- design/write_back_record_cache.sv -----
// Write-back record cache, top level: controller plus datapath.
// The request is captured on acceptance and decided in ST_DECIDE; the first result
// is loaded into the output register in ST_EMIT1 and a second one in ST_EMIT2.
// Flush all walks every entry through ST_SWEEP and ST_SWEMIT, plus any wait on the
// single-slot output register. Reset: asynchronous, clears valid, dirty and
// pending-fetch state; tags and words stay unknown until written.
module write_back_record_cache #(
	parameter int ENTRIES    = 16,
	parameter int INDEX_BITS = 16,
	parameter int DATA_BITS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            op,
	input  logic [INDEX_BITS-1:0] record_index,
	input  logic [DATA_BITS-1:0]  record_data,
	input  logic [15:0]           victim_hint,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [INDEX_BITS-1:0] result_index,
	output logic [DATA_BITS-1:0]  result_data,
	output logic                  last
);

	wbrc_pkg::dp_cmd_t  cmd;
	wbrc_pkg::dp_stat_t stat;

	wbrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	wbrc_datapath #(
		.ENTRIES    (ENTRIES),
		.INDEX_BITS (INDEX_BITS),
		.DATA_BITS  (DATA_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.record_index (record_index),
		.record_data  (record_data),
		.victim_hint  (victim_hint),
		.kind         (kind),
		.result_index (result_index),
		.result_data  (result_data),
		.last         (last)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(result_data))
		else $error("result payload changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(last))
		else $error("last flag changed while stalled");

endmodule
